@@ sv/ret_pkg.sv @@
// Ring exit test: shared widths, config register indices, ray and verdict payloads.
// No dependencies.
package ret_pkg;

  localparam int PosW = 20;
  localparam int DirW = 16;
  localparam int RadW = 19;
  localparam int RegIdxW = 2;
  localparam int CfgDataW = 20;

  typedef enum logic [RegIdxW-1:0] {
    REG_TOP_EDGE    = 2'd0,
    REG_BOTTOM_EDGE = 2'd1,
    REG_RING_RADIUS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
    logic signed [DirW-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic exits_ring;
    logic not_inside;
  } verdict_t;

endpackage

@@ sv/ret_if.sv @@
// Valid/ready channel interfaces for the ring exit test.
// Depends on ret_pkg.
interface ret_ray_if (input logic clk);
  logic          valid;
  logic          ready;
  ret_pkg::ray_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ret_verdict_if (input logic clk);
  logic              valid;
  logic              ready;
  ret_pkg::verdict_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/ret_pipe.sv @@
// Ring exit test arithmetic pipeline: eight register stages, global enable.
// Depends on ret_pkg.
module ret_pipe (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  ret_pkg::ray_t                  in_data,
  input  logic signed [ret_pkg::PosW-1:0] top_edge_z,
  input  logic signed [ret_pkg::PosW-1:0] bottom_edge_z,
  input  logic [ret_pkg::RadW-1:0]       ring_radius,
  output logic                           out_valid,
  output ret_pkg::verdict_t              out_data
);

  localparam int Depth = 8;
  logic [Depth-1:0] vld;

  // s1: squares and dot products (each <=32x32)
  logic signed [40:0] pxx, pyy, pxdx, pydy;
  logic signed [32:0] dxx, dyy;
  logic [37:0] rr;
  logic signed [20:0] up_d, lo_d;
  logic signed [ret_pkg::DirW-1:0] dz1;
  logic vert1;
  // s2: sums
  logic signed [41:0] psq2, b2;
  logic signed [33:0] q2;
  logic [37:0] rsq2;
  logic signed [20:0] up2, lo2;
  logic signed [15:0] dz2;
  logic vert2;
  // s3: inside test, E = R^2 - |p|^2, |b|
  logic out3, vert3;
  logic [37:0] e3;
  logic [36:0] bmag3;
  logic signed [41:0] b3;
  logic signed [33:0] q3;
  logic signed [20:0] up3, lo3;
  logic signed [15:0] dz3;
  // s4: partial products of b^2 and q*E, edge terms
  logic [37:0] bbhh4;
  logic [36:0] bbhl4;
  logic [35:0] bbll4;
  logic [50:0] qeh4, qel4;
  logic signed [55:0] upq4, loq4, bdz4;
  logic [30:0] dzz4;
  logic signed [15:0] dz4;
  logic out4, vert4;
  // s5: discriminant and edge comparands
  logic [74:0] disc5;
  logic signed [57:0] cup5, clo5;
  logic [30:0] dzz5;
  logic signed [15:0] dz5;
  logic out5, vert5;
  // s6: partial products of disc*dz^2 and c^2
  logic [55:0] ddp0_6, ddp1_6, ddp2_6;
  logic [51:0] cuphh6, clohh6;
  logic [52:0] cuphl6, clohl6;
  logic [53:0] cupll6, clolll6;
  logic signed [57:0] cup6, clo6;
  logic signed [15:0] dz6;
  logic out6, vert6;
  // s7: summed squares
  logic [116:0] dd7;
  logic [115:0] cupsq7, closq7;
  logic signed [57:0] cup7, clo7;
  logic signed [15:0] dz7;
  logic out7, vert7;

  logic [36:0] b_mag;
  logic [52:0] cup_mag, clo_mag;
  assign b_mag   = b2[41] ? 37'(-b2) : 37'(b2);
  assign cup_mag = cup5[57] ? 53'(-cup5) : 53'(cup5);
  assign clo_mag = clo5[57] ? 53'(-clo5) : 53'(clo5);

  function automatic logic [1:0] sgn(input logic signed [15:0] dz, input logic [116:0] dd,
                                     input logic [115:0] csq, input logic signed [57:0] c);
    // 2'b01 positive, 2'b11 negative, 2'b00 zero
    logic [1:0] cmp;
    cmp = (dd > {1'b0, csq}) ? 2'b01 : ((dd < {1'b0, csq}) ? 2'b11 : 2'b00);
    if (dz == 16'sd0) sgn = (c > 0) ? 2'b11 : ((c < 0) ? 2'b01 : 2'b00);
    else if (dz > 0) sgn = (c < 0) ? 2'b01 : cmp;
    else sgn = (c > 0) ? 2'b11 : ((cmp == 2'b00) ? 2'b00 : {1'b1, 1'b1} ^ {cmp[1], 1'b0});
  endfunction

  logic [1:0] s_up, s_lo;
  assign s_up = sgn(dz7, dd7, cupsq7, cup7);
  assign s_lo = sgn(dz7, dd7, closq7, clo7);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx   <= 41'(in_data.pos_x * in_data.pos_x);
      pyy   <= 41'(in_data.pos_y * in_data.pos_y);
      pxdx  <= 41'(in_data.pos_x * in_data.dir_x);
      pydy  <= 41'(in_data.pos_y * in_data.dir_y);
      dxx   <= 33'(in_data.dir_x * in_data.dir_x);
      dyy   <= 33'(in_data.dir_y * in_data.dir_y);
      rr    <= 38'(ring_radius * ring_radius);
      up_d  <= 21'(top_edge_z) - 21'(in_data.pos_z);
      lo_d  <= 21'(bottom_edge_z) - 21'(in_data.pos_z);
      dz1   <= in_data.dir_z;
      vert1 <= (in_data.dir_x == '0) && (in_data.dir_y == '0);

      psq2 <= 42'(pxx) + 42'(pyy);
      b2   <= 42'(pxdx) + 42'(pydy);
      q2   <= 34'(dxx) + 34'(dyy);
      rsq2 <= rr; up2 <= up_d; lo2 <= lo_d; dz2 <= dz1; vert2 <= vert1;

      // E only matters when inside, where it is below 2^38
      out3  <= $signed({1'b0, rsq2}) <= 43'(psq2);
      e3    <= rsq2 - psq2[37:0];
      bmag3 <= b_mag;
      b3 <= b2; q3 <= q2; up3 <= up2; lo3 <= lo2; dz3 <= dz2; vert3 <= vert2;

      // |b| = bh*2^18 + bl, E = eh*2^19 + el
      bbhh4 <= bmag3[36:18] * bmag3[36:18];
      bbhl4 <= bmag3[36:18] * bmag3[17:0];
      bbll4 <= bmag3[17:0] * bmag3[17:0];
      qeh4  <= q3[31:0] * e3[37:19];
      qel4  <= q3[31:0] * e3[18:0];
      upq4  <= 56'(up3 * q3);
      loq4  <= 56'(lo3 * q3);
      bdz4  <= 56'(b3 * dz3);
      dzz4  <= 31'(dz3 * dz3);
      dz4 <= dz3; out4 <= out3; vert4 <= vert3;

      disc5 <= (75'(bbhh4) << 36) + (75'(bbhl4) << 19) + 75'(bbll4) +
               (75'(qeh4) << 19) + 75'(qel4);
      cup5  <= 58'(upq4) + 58'(bdz4);
      clo5  <= 58'(loq4) + 58'(bdz4);
      dzz5 <= dzz4; dz5 <= dz4; out5 <= out4; vert5 <= vert4;

      // disc in 25-bit slices; |c| = ch*2^27 + cl
      ddp0_6  <= disc5[24:0] * dzz5;
      ddp1_6  <= disc5[49:25] * dzz5;
      ddp2_6  <= disc5[74:50] * dzz5;
      cuphh6  <= cup_mag[52:27] * cup_mag[52:27];
      cuphl6  <= cup_mag[52:27] * cup_mag[26:0];
      cupll6  <= cup_mag[26:0] * cup_mag[26:0];
      clohh6  <= clo_mag[52:27] * clo_mag[52:27];
      clohl6  <= clo_mag[52:27] * clo_mag[26:0];
      clolll6 <= clo_mag[26:0] * clo_mag[26:0];
      cup6 <= cup5; clo6 <= clo5; dz6 <= dz5; out6 <= out5; vert6 <= vert5;

      dd7    <= (117'(ddp2_6) << 50) + (117'(ddp1_6) << 25) + 117'(ddp0_6);
      cupsq7 <= (116'(cuphh6) << 54) + (116'(cuphl6) << 28) + 116'(cupll6);
      closq7 <= (116'(clohh6) << 54) + (116'(clohl6) << 28) + 116'(clolll6);
      cup7 <= cup6; clo7 <= clo6; dz7 <= dz6; out7 <= out6; vert7 <= vert6;

      out_data.not_inside <= out7;
      out_data.exits_ring <= !out7 && (vert7 || (s_up == 2'b01) || (s_lo == 2'b11));
    end
  end

  assign out_valid = vld[Depth-1];

endmodule

@@ sv/ring_exit_test_core.sv @@
// Ring exit test top level: config registers, pipeline, output skid buffer.
// Depends on ret_pkg, ret_if, ret_pipe.
//
//  channel | dir | beat payload
//  ray     | in  | pos_x/y/z (20b s), dir_x/y/z (16b s)
//  verdict | out | exits_ring, not_inside
//
// One beat per cycle while the buffer is not full. A ray's verdict passes
// through the eight pipeline stages, then the output buffer, before it is
// offered on the verdict channel.
// ray.ready depends only on the buffer count: it drops while both buffer
// entries hold waiting beats, and then the whole pipeline holds.
// Reset (rst, synchronous) clears valid bits and the buffer count and loads
// the default edges and radius. Nothing is dropped under stalls.
module ring_exit_test_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ret_pkg::RegIdxW-1:0]     cfg_idx,
  input  logic [ret_pkg::CfgDataW-1:0]    cfg_data,
  ret_ray_if.sink                         ray,
  ret_verdict_if.source                   verdict
);

  logic signed [ret_pkg::PosW-1:0] top_edge_z, bottom_edge_z;
  logic [ret_pkg::RadW-1:0] ring_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_edge_z    <= 20'sd1600;
      bottom_edge_z <= -20'sd1600;
      ring_radius   <= 19'd16000;
    end else if (cfg_we) begin
      case (ret_pkg::cfg_reg_t'(cfg_idx))
        ret_pkg::REG_TOP_EDGE:    top_edge_z    <= cfg_data;
        ret_pkg::REG_BOTTOM_EDGE: bottom_edge_z <= cfg_data;
        ret_pkg::REG_RING_RADIUS: ring_radius   <= cfg_data[ret_pkg::RadW-1:0];
        default: ;
      endcase
    end
  end

  // Output skid: two entries. Pipeline runs unless both entries are taken,
  // so the head beat always has a slot.
  logic en, p_valid;
  ret_pkg::verdict_t p_data;
  ret_pkg::verdict_t buf0, buf1;
  logic [1:0] cnt;
  logic push, pop;

  assign en = (cnt != 2'd2);
  assign ray.ready = en;
  assign push = en && p_valid;
  assign pop  = verdict.valid && verdict.ready;

  ret_pipe u_pipe (
    .clk, .rst, .en,
    .in_valid (ray.valid && en),
    .in_data  (ray.data),
    .top_edge_z, .bottom_edge_z, .ring_radius,
    .out_valid (p_valid),
    .out_data  (p_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0 <= (cnt == 2'd2) ? buf1 : p_data;
      if (push && cnt == 2'd2) buf1 <= p_data;
    end else if (push) begin
      if (cnt == 2'd0) buf0 <= p_data;
      else buf1 <= p_data;
    end
  end

  assign verdict.valid = (cnt != 2'd0);
  assign verdict.data  = buf0;

  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("skid overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !verdict.ready) |-> !push) else $error("push into full skid");
  a_out_excl: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> !(verdict.data.exits_ring && verdict.data.not_inside))
    else $error("exit flagged for outside point");

endmodule
